// File: hdl/fsf_pkg.sv
// shared constants and helpers for the flash signal synthesis datapath
// no dependencies; used by fsf_exp and flash_signal_synthesis
package fsf_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TR  = 2'd0,
    REG_SIN = 2'd1,
    REG_COS = 2'd2
  } cfg_reg_e;

  localparam logic [DATA_W-1:0] TR_RST  = 16'd320;
  localparam logic [DATA_W-1:0] SIN_RST = 16'd2856;
  localparam logic [DATA_W-1:0] COS_RST = 16'd16135;

  // q31 fixed point helpers for the exponential
  localparam logic [31:0] Q31_ONE   = 32'h8000_0000;
  localparam logic [63:0] Q31_ROUND = 64'h0000_0000_4000_0000;

  // reciprocal of k in q31, rounded up; exact floor for 28-bit operands
  function automatic logic [31:0] recip_q31(input int k);
    logic [31:0] m;
    case (k)
      1:       m = 32'h8000_0000;
      2:       m = 32'h4000_0000;
      3:       m = 32'd715827883;
      4:       m = 32'h2000_0000;
      5:       m = 32'd429496730;
      default: m = 32'd357913942;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/fsf_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// no package dependencies; instantiated by flash_signal_synthesis
module fsf_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 19,
  parameter int QUO_W = 21,
  parameter int SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic             vld_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic [NUM_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [SB_W-1:0]  sb_q  [QUO_W+1];

  // entry stage: quotient must fit in QUO_W bits
  logic ovf_d;
  assign ovf_d = CMP_W'(num_i) >= (CMP_W'(den_i) << QUO_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= ovf_d;
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sb_q[0]  <= sb_i;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar i = 1; i <= QUO_W; i++) begin : g_stage
    localparam int B = QUO_W - i;
    logic [CMP_W-1:0] sh;
    logic [CMP_W-1:0] diff;
    logic             ge;
    logic [NUM_W-1:0] rem_d;
    logic [QUO_W-1:0] quo_d;

    assign sh   = CMP_W'(den_q[i-1]) << B;
    assign ge   = CMP_W'(rem_q[i-1]) >= sh;
    assign diff = CMP_W'(rem_q[i-1]) - sh;

    always_comb begin
      quo_d    = quo_q[i-1];
      quo_d[B] = ge;
      rem_d    = ge ? diff[NUM_W-1:0] : rem_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[i] <= ovf_q[i-1];
        rem_q[i] <= rem_d;
        den_q[i] <= den_q[i-1];
        quo_q[i] <= quo_d;
        sb_q[i]  <= sb_q[i-1];
      end
    end
  end

  assign vld_o = vld_q[QUO_W];
  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];
  assign sb_o  = sb_q[QUO_W];

endmodule

// File: hdl/fsf_exp.sv
// pipelined exp(-x): six horner steps of a taylor series on x/256, then eight squarings
// uses fsf_pkg for q31 constants and reciprocals; instantiated by flash_signal_synthesis
module fsf_exp #(
  parameter int EXP_FRAC_BITS = 16,
  parameter int SB_W          = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [EXP_FRAC_BITS+4:0] x_i,
  input  logic                     zero_i,
  input  logic [SB_W-1:0]          sb_i,
  output logic                     vld_o,
  output logic [EXP_FRAC_BITS:0]   e1_o,
  output logic [SB_W-1:0]          sb_o
);

  localparam int F   = EXP_FRAC_BITS;
  localparam int NST = 21;

  logic            vld_q  [NST];
  logic            zero_q [NST];
  logic [SB_W-1:0] sb_q   [NST];
  logic [27:0]     y_q    [NST];
  logic [63:0]     acc_q  [NST];

  // entry stage: y = x / 256 in q31
  logic [35:0] xs;
  assign xs = 36'(x_i) << (31 - F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= zero_i;
      sb_q[0]   <= sb_i;
      y_q[0]    <= xs[35:8];
      acc_q[0]  <= '0;
    end
  end

  // odd stages up to 11 multiply y*p, even stages up to 12 divide by k,
  // stages 13 to 20 square
  for (genvar j = 1; j < NST; j++) begin : g_stage
    logic [63:0] acc_d;

    if (j <= 12 && (j % 2) == 0) begin : g_div
      localparam int K = 6 - (j - 2) / 2;
      assign acc_d = {36'd0, acc_q[j-1][58:31]} * {32'd0, fsf_pkg::recip_q31(K)};
    end else begin : g_mul
      logic [31:0] p;
      if ((j % 2) == 1 && j <= 13) begin : g_sub
        assign p = fsf_pkg::Q31_ONE - acc_q[j-1][62:31];
      end else begin : g_rnd
        logic [63:0] rnd;
        assign rnd = acc_q[j-1] + fsf_pkg::Q31_ROUND;
        assign p   = rnd[62:31];
      end
      if (j <= 12) begin : g_horner
        assign acc_d = {36'd0, y_q[j-1]} * {32'd0, p};
      end else begin : g_square
        assign acc_d = {32'd0, p} * {32'd0, p};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[j] <= zero_q[j-1];
        sb_q[j]   <= sb_q[j-1];
        y_q[j]    <= y_q[j-1];
        acc_q[j]  <= acc_d;
      end
    end
  end

  // last squaring rounded, then q31 down to F fraction bits
  logic [63:0] rnd_l;
  logic [31:0] p_l;
  logic [32:0] e_sum;
  logic [32:0] e_sh;
  logic [F:0]  e1_d;

  assign rnd_l = acc_q[NST-1] + fsf_pkg::Q31_ROUND;
  assign p_l   = rnd_l[62:31];
  assign e_sum = 33'(p_l) + (33'(1) << (30 - F));
  assign e_sh  = e_sum >> (31 - F);
  assign e1_d  = zero_q[NST-1] ? '0 : e_sh[F:0];

  logic            vld_out_q;
  logic [F:0]      e1_q;
  logic [SB_W-1:0] sb_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q     <= e1_d;
      sb_out_q <= sb_q[NST-1];
    end
  end

  assign vld_o = vld_out_q;
  assign e1_o  = e1_q;
  assign sb_o  = sb_out_q;

endmodule

// File: hdl/flash_signal_synthesis.sv
// top level: flash signal pd*sin(a)*(1-e1)/(1-cos(a)*e1), e1 = exp(-tr/t1)
// depends on fsf_pkg, fsf_div and fsf_exp
//
//   port group   dir   payload                         role
//   s_axis       in    tdata[15:0] t1, [31:16] pd      voxel beat
//   m_axis       out   tdata[15:0] signal_value        result beat
//   cfg          in    we, idx[1:0], data[15:0]        register write
//
// one beat per cycle in and out; the pipeline depth is set mainly by the two bit-per-stage
// dividers and the 22-stage exponential
// reset clears all valid bits and loads the register defaults
// the whole pipeline holds while a result waits and m_axis_tready is low
module flash_signal_synthesis #(
  parameter int EXP_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // t1_time, proton_density
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // signal_value
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int F      = EXP_FRAC_BITS;
  localparam int N1_W   = F + 17;
  localparam int D1_W   = 19;
  localparam int Q1_W   = F + 5;
  localparam int DEN_SW = F + 17;
  localparam int DM_W   = F + 16;
  localparam int N2_W   = 2 * F + 16;
  localparam int Q2_W   = F + 9;
  localparam int PROD_W = F + 40;
  localparam int SB1_W  = 33;
  localparam int SB2_W  = 35;

  // configuration registers
  logic [15:0] tr_q, sin_q, cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q  <= fsf_pkg::TR_RST;
      sin_q <= fsf_pkg::SIN_RST;
      cos_q <= fsf_pkg::COS_RST;
    end else if (cfg_we_i) begin
      case (fsf_pkg::cfg_reg_e'(cfg_idx_i))
        fsf_pkg::REG_TR:  tr_q  <= cfg_data_i;
        fsf_pkg::REG_SIN: sin_q <= cfg_data_i;
        fsf_pkg::REG_COS: cos_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: move when the output register is free or taken
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // input beat: tr/(16*t1) operands and |pd|*|sin|
  logic [15:0]     t1, pd, apd, asin;
  logic            pos;
  logic [31:0]     psm_full;
  logic [N1_W-1:0] n1;
  logic [D1_W-1:0] d1;
  logic [SB1_W-1:0] sb1_in;

  assign t1       = s_axis_tdata[15:0];
  assign pd       = s_axis_tdata[31:16];
  assign pos      = !t1[15] && (t1 != '0);
  assign apd      = pd[15] ? 16'(-pd) : pd;
  assign asin     = sin_q[15] ? 16'(-sin_q) : sin_q;
  assign psm_full = apd * asin;
  assign n1       = (N1_W'(tr_q) << F) + N1_W'({t1[14:0], 3'b000});
  assign d1       = {t1[14:0], 4'b0000};
  assign sb1_in   = {pd[15] ^ sin_q[15], psm_full[30:0], pos};

  logic             div1_vld;
  logic [Q1_W-1:0]  div1_quo;
  logic             div1_ovf;
  logic [SB1_W-1:0] div1_sb;

  fsf_div #(
    .NUM_W (N1_W),
    .DEN_W (D1_W),
    .QUO_W (Q1_W),
    .SB_W  (SB1_W)
  ) u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .num_i  (n1),
    .den_i  (d1),
    .sb_i   (sb1_in),
    .vld_o  (div1_vld),
    .quo_o  (div1_quo),
    .ovf_o  (div1_ovf),
    .sb_o   (div1_sb)
  );

  logic             exp_vld;
  logic [F:0]       exp_e1;
  logic [SB1_W-1:0] exp_sb;

  fsf_exp #(
    .EXP_FRAC_BITS (F),
    .SB_W          (SB1_W)
  ) u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (div1_vld),
    .x_i    (div1_quo),
    .zero_i (div1_ovf),
    .sb_i   (div1_sb),
    .vld_o  (exp_vld),
    .e1_o   (exp_e1),
    .sb_o   (exp_sb)
  );

  // numerator and signed denominator of the relaxation ratio
  localparam logic [DEN_SW-1:0] DEN_ONE = DEN_SW'(1) << (F + 14);
  localparam logic [F:0]        NUM_ONE = (F + 1)'(1) << F;

  logic signed [DEN_SW-1:0] ce;
  logic [DEN_SW-1:0]        den_d;
  logic                     dn_vld_q;
  logic [DEN_SW-1:0]        den_q;
  logic [F:0]               num_q;
  logic [SB1_W-1:0]         dn_sb_q;

  assign ce    = $signed(cos_q) * $signed({1'b0, exp_e1});
  assign den_d = DEN_ONE - DEN_SW'(ce);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_vld_q <= 1'b0;
    end else if (en) begin
      dn_vld_q <= exp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q   <= den_d;
      num_q   <= NUM_ONE - exp_e1;
      dn_sb_q <= exp_sb;
    end
  end

  // magnitude of the denominator and rounded dividend
  logic [DEN_SW-1:0] den_abs;
  logic [N2_W-1:0]   n2_d;
  logic              mg_vld_q;
  logic [N2_W-1:0]   n2_q;
  logic [DM_W-1:0]   dm_q;
  logic [SB2_W-1:0]  mg_sb_q;

  assign den_abs = den_q[DEN_SW-1] ? DEN_SW'(-den_q) : den_q;
  assign n2_d    = (N2_W'(num_q) << (F + 14)) + N2_W'(den_abs[DM_W-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_vld_q <= 1'b0;
    end else if (en) begin
      mg_vld_q <= dn_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q    <= n2_d;
      dm_q    <= den_abs[DM_W-1:0];
      mg_sb_q <= {dn_sb_q, den_q[DEN_SW-1], den_q == '0};
    end
  end

  logic             div2_vld;
  logic [Q2_W-1:0]  div2_quo;
  logic             div2_ovf;
  logic [SB2_W-1:0] div2_sb;

  fsf_div #(
    .NUM_W (N2_W),
    .DEN_W (DM_W),
    .QUO_W (Q2_W),
    .SB_W  (SB2_W)
  ) u_div_factor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mg_vld_q),
    .num_i  (n2_q),
    .den_i  (dm_q),
    .sb_i   (mg_sb_q),
    .vld_o  (div2_vld),
    .quo_o  (div2_quo),
    .ovf_o  (div2_ovf),
    .sb_o   (div2_sb)
  );

  // select the ratio: one for nonpositive t1, zero for zero denominator, clamp
  localparam logic [Q2_W-1:0] R_LIMIT = Q2_W'(1) << (F + 8);
  localparam logic [Q2_W-1:0] R_ONE   = Q2_W'(1) << F;

  logic            r_sgn, r_pos, r_rneg, r_dzero;
  logic [30:0]     r_psm;
  logic [Q2_W-1:0] rm_d;
  logic            rs_vld_q;
  logic [Q2_W-1:0] rm_q;
  logic [30:0]     rs_psm_q;
  logic            rs_neg_q;

  assign {r_sgn, r_psm, r_pos, r_rneg, r_dzero} = div2_sb;

  always_comb begin
    if (!r_pos) begin
      rm_d = R_ONE;
    end else if (r_dzero) begin
      rm_d = '0;
    end else if (div2_ovf || div2_quo > R_LIMIT) begin
      rm_d = R_LIMIT;
    end else begin
      rm_d = div2_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_vld_q <= 1'b0;
    end else if (en) begin
      rs_vld_q <= div2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rm_q     <= rm_d;
      rs_psm_q <= r_psm;
      rs_neg_q <= r_sgn ^ (r_pos && !r_dzero && r_rneg);
    end
  end

  // full magnitude product
  logic              pr_vld_q;
  logic [PROD_W-1:0] prod_q;
  logic              pr_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else if (en) begin
      pr_vld_q <= rs_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= PROD_W'(rs_psm_q) * PROD_W'(rm_q);
      pr_neg_q <= rs_neg_q;
    end
  end

  // round half away from zero, saturate, output register
  logic [PROD_W-1:0]        sum;
  logic [PROD_W-F-15:0]     mag;
  logic [15:0]              res_d;
  logic [15:0]              res_q;

  assign sum = prod_q + (PROD_W'(1) << (F + 13));
  assign mag = sum[PROD_W-1:F+14];

  always_comb begin
    if (mag == '0) begin
      res_d = '0;
    end else if (pr_neg_q) begin
      res_d = (mag > 26'd32768) ? 16'h8000 : 16'(-mag[15:0]);
    end else begin
      res_d = (mag > 26'd32767) ? 16'h7fff : mag[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

endmodule
